@@ design/olist_pkg.sv @@
package olist_pkg;

  // list sizing
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // operation codes
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELPOS = 3'd2;
  localparam logic [2:0] OP_DELVAL = 3'd3;
  localparam logic [2:0] OP_SEARCH = 3'd4;
  localparam logic [2:0] OP_SHOW   = 3'd5;
  localparam logic [2:0] OP_CLEAR  = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [4:0]         position;
  } olist_cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic signed [31:0] element;
    logic [CNT_W-1:0]   count;
    logic               last;
  } olist_res_t;

endpackage

@@ design/olist_ram.sv @@
module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ordered_list_engine.sv @@
// Ordered list of up to CAPACITY signed 32-bit values held in a single-port-write,
// registered-read RAM. A transaction is taken when start is high and busy is low;
// every result appears on res_o for one cycle with res_valid_o high and cannot be
// held off. Append, clear, insert at the end and rejected operations are answered
// directly from the idle state. Insert and delete move the tail one entry at a
// time (read, then write back). Search and delete by value scan the entries in
// order, reading then comparing each one. Display emits the elements in order.
// No clearing pass follows reset.
module ordered_list_engine
  import olist_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  olist_cmd_t cmd_i,
  output logic       res_valid_o,
  output olist_res_t res_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SHUP_RD = 4'd1;
  localparam logic [3:0] S_SHUP_WR = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_SHDN_RD = 4'd4;
  localparam logic [3:0] S_SHDN_WR = 4'd5;
  localparam logic [3:0] S_SCAN_RD = 4'd6;
  localparam logic [3:0] S_SCAN_CM = 4'd7;
  localparam logic [3:0] S_DISP_RD = 4'd8;
  localparam logic [3:0] S_DISP_OUT = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [2:0]       op_q, op_d;
  logic [31:0]      val_q, val_d;
  logic [CNT_W-1:0] tgt_q, tgt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             res_valid_q, res_valid_d;
  olist_res_t       res_q, res_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  logic             accept;
  logic [CNT_W:0]   pos_ext;
  logic [CNT_W:0]   cnt_ext;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] idx_p1;
  logic [CNT_W-1:0] idx_m1;

  assign accept  = start && !busy;
  assign pos_ext = {1'b0, cmd_i.position};
  assign cnt_ext = {1'b0, cnt_q};
  assign pos_m1  = cmd_i.position - 5'd1;
  assign idx_p1  = idx_q + CNT_W'(1);
  assign idx_m1  = idx_q - CNT_W'(1);

  // entry store
  olist_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // sequencer: read, modify, write back
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    tgt_d       = tgt_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[IDX_W-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = cmd_i.operation;
          val_d = cmd_i.value;
          res_valid_d = 1'b1;
          case (cmd_i.operation) inside
            OP_APPEND: begin
              if (cnt_q == CNT_W'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[IDX_W-1:0];
                ram_wdata = cmd_i.value;
                cnt_d     = cnt_q + CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (cmd_i.position == 5'd0 || pos_ext > cnt_ext + 6'd1) begin
                res_d.status = ST_BADPOS;
              end else if (cnt_q == CNT_W'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else if (pos_m1 == cnt_q) begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[IDX_W-1:0];
                ram_wdata = cmd_i.value;
                cnt_d     = cnt_q + CNT_W'(1);
              end else begin
                res_valid_d = 1'b0;
                tgt_d       = pos_m1;
                idx_d       = cnt_q;
                state_d     = S_SHUP_RD;
              end
            end
            OP_DELPOS: begin
              if (cmd_i.position == 5'd0 || pos_ext > cnt_ext) begin
                res_d.status = ST_BADPOS;
              end else begin
                res_valid_d = 1'b0;
                idx_d       = pos_m1;
                state_d     = S_SHDN_RD;
              end
            end
            OP_DELVAL, OP_SEARCH: begin
              res_valid_d = 1'b0;
              idx_d       = '0;
              state_d     = S_SCAN_RD;
            end
            OP_SHOW: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                res_valid_d = 1'b0;
                idx_d       = '0;
                state_d     = S_DISP_RD;
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // open a gap: move entry idx-1 up to idx
      S_SHUP_RD: begin
        ram_raddr = idx_m1[IDX_W-1:0];
        state_d   = S_SHUP_WR;
      end
      S_SHUP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[IDX_W-1:0];
        idx_d     = idx_m1;
        state_d   = (idx_m1 == tgt_q) ? S_INS_WR : S_SHUP_RD;
      end
      S_INS_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = tgt_q[IDX_W-1:0];
        ram_wdata   = val_q;
        cnt_d       = cnt_q + CNT_W'(1);
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      // close a gap: move entry idx+1 down to idx
      S_SHDN_RD: begin
        if (idx_p1 < cnt_q) begin
          ram_raddr = idx_p1[IDX_W-1:0];
          state_d   = S_SHDN_WR;
        end else begin
          cnt_d       = cnt_q - CNT_W'(1);
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SHDN_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_p1;
        state_d = S_SHDN_RD;
      end
      // linear scan for the first match
      S_SCAN_RD: begin
        if (idx_q < cnt_q) begin
          state_d = S_SCAN_CM;
        end else begin
          res_valid_d  = 1'b1;
          res_d.status = (op_q == OP_DELVAL) ? ST_NOTFOUND : ST_OK;
          state_d      = S_IDLE;
        end
      end
      S_SCAN_CM: begin
        if (ram_rdata == val_q) begin
          if (op_q == OP_SEARCH) begin
            res_valid_d = 1'b1;
            res_d.found = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_SHDN_RD;
          end
        end else begin
          idx_d   = idx_p1;
          state_d = S_SCAN_RD;
        end
      end
      // stream the elements in order
      S_DISP_RD: begin
        state_d = S_DISP_OUT;
      end
      S_DISP_OUT: begin
        res_valid_d   = 1'b1;
        res_d.element = ram_rdata;
        res_d.last    = (idx_p1 == cnt_q);
        idx_d         = idx_p1;
        state_d       = (idx_p1 == cnt_q) ? S_IDLE : S_DISP_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.count = cnt_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    tgt_q <= tgt_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.count <= CNT_W'(CAPACITY))
    else $error("result count above capacity");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != ST_OK) |-> res_o.last)
    else $error("error status on a non-final result");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.found) |-> (res_o.status == ST_OK && res_o.element == 32'sd0))
    else $error("found flag with bad status or element");

  a_idle_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !$past(busy) && !res_valid_o) |=> busy || res_valid_o)
    else $error("operation finished without a result");
`endif

endmodule
